[rtl/uels_pkg.sv]
`timescale 1ns / 1ps

package uels_pkg;

   localparam int unsigned CAPACITY_DEF = 512;

   localparam int DATA_W  = 32;
   localparam int DIFF_W  = DATA_W + 1;
   localparam int MUL_A_W = DATA_W + 2;
   localparam int MUL_B_W = DATA_W + 1;
   localparam int HALF_W  = 16;
   localparam int PART_W  = MUL_A_W + HALF_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int VALUE_W = 64;
   localparam int KEPT_W  = 10;
   localparam int FUNC_W  = 2;
   localparam int STATUS_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;

   typedef struct packed {
      logic signed [DATA_W-1:0] slope;
      logic signed [DATA_W-1:0] intercept;
   } line_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_ANSWERED  = 3'd1,
      ST_SLOPE_BAD = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_CHK,
      S_ADD_RD,
      S_ADD_M1,
      S_ADD_M2,
      S_ADD_END,
      S_Q_CHK,
      S_Q_RD0,
      S_Q_RD1,
      S_Q_M,
      S_Q_FRD,
      S_Q_FM,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic                     busy;
      logic signed [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

[rtl/uels_mem.sv]
`timescale 1ns / 1ps

module uels_mem #(
   parameter int unsigned DEPTH = uels_pkg::CAPACITY_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  uels_pkg::line_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output uels_pkg::line_type rd_data
);

   uels_pkg::line_type line_mem_ff [DEPTH];
   uels_pkg::line_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/uels_mul.sv]
`timescale 1ns / 1ps

module uels_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  uels_pkg::mul_req_type req,
   output uels_pkg::mul_rsp_type rsp
);

   logic [1:0] phase_ff, phase_in;
   logic       done_ff, done_in;

   logic signed [uels_pkg::MUL_A_W-1:0]  a_ff;
   logic signed [uels_pkg::MUL_B_W-1:0]  b_ff;
   logic signed [uels_pkg::PART_W-1:0]   p0_ff, p1_ff;
   logic signed [uels_pkg::PROD_W-1:0]   prod_ff;

   logic signed [uels_pkg::HALF_W:0]     b_lo;
   logic signed [uels_pkg::HALF_W:0]     b_hi;
   logic signed [uels_pkg::PROD_W-1:0]   p0_wide, p1_wide;

   // split b into a zero-extended low half and a signed high half
   assign b_lo = $signed({1'b0, b_ff[uels_pkg::HALF_W-1:0]});
   assign b_hi = b_ff[uels_pkg::MUL_B_W-1:uels_pkg::HALF_W];
   assign p0_wide = p0_ff;
   assign p1_wide = p1_ff;

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      case (phase_ff)
         2'd0: if (req.start) phase_in = 2'd1;
         2'd1: phase_in = 2'd2;
         2'd2: phase_in = 2'd3;
         2'd3: begin
            phase_in = 2'd0;
            done_in  = 1'b1;
         end
         default: phase_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start && phase_ff == 2'd0) begin
         a_ff <= req.a;
         b_ff <= req.b;
      end
      if (phase_ff == 2'd1) begin
         p0_ff <= a_ff * b_lo;
      end
      if (phase_ff == 2'd2) begin
         p1_ff <= a_ff * b_hi;
      end
      if (phase_ff == 2'd3) begin
         prod_ff <= p0_wide + (p1_wide <<< uels_pkg::HALF_W);
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.busy    = (phase_ff != 2'd0);
   assign rsp.product = prod_ff;

endmodule

[rtl/upper_envelope_line_stack.sv]
`timescale 1ns / 1ps
// Flow: clear, refused add and empty query go straight to the result once accepted;
//   an add runs at most one pop test per popped line plus one;
//   a query runs a binary search over the breakpoints, then evaluates the chosen line.
// Throughput: one transaction at a time; the shared 34x33 multiplier (two 34x17 partial products)
//   and the single read port of the line memory set the cost of each step.
// Reset: synchronous, active high; clears the line count and control state, no memory sweep.

module upper_envelope_line_stack #(
   parameter int unsigned CAPACITY = uels_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [uels_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [uels_pkg::DATA_W-1:0]    req_slope,
   input  logic signed [uels_pkg::DATA_W-1:0]    req_intercept,
   input  logic signed [uels_pkg::DATA_W-1:0]    req_query_x,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [uels_pkg::VALUE_W-1:0]   rsp_best_value,
   output logic [uels_pkg::STATUS_W-1:0]         rsp_status,
   output logic [uels_pkg::KEPT_W-1:0]           rsp_lines_kept
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [CW-1:0] TWO_C = CW'(2);

   // ---------------------------------------------------------------
   // Control and working registers
   // ---------------------------------------------------------------
   uels_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;     // lines on the stack
   uels_pkg::line_type   top_ff, top_in;         // copy of the top entry
   uels_pkg::line_type   new_ff, new_in;         // line being added
   logic signed [uels_pkg::DATA_W-1:0] x_ff, x_in;
   logic [CW-1:0]        n_ff, n_in;             // stack height while popping
   uels_pkg::line_type   cur1_ff, cur1_in;       // lower line of the pair under test
   uels_pkg::line_type   cur2_ff, cur2_in;       // upper line of the pair under test
   logic [CW-1:0]        lo_ff, lo_in;           // search window [lo, hi1)
   logic [CW-1:0]        hi1_ff, hi1_in;
   logic [CW-1:0]        mid_ff, mid_in;
   logic signed [uels_pkg::PROD_W-1:0] prod1_ff, prod1_in;
   logic signed [uels_pkg::VALUE_W-1:0] val_ff, val_in;
   uels_pkg::status_type st_ff, st_in;

   // output register: holds a result while the next transaction is taken
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [uels_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [uels_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [uels_pkg::KEPT_W-1:0]          rsp_kept_ff, rsp_kept_in;

   // memory and multiplier hookup
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   uels_pkg::line_type    rd_data;
   uels_pkg::mul_req_type mul_req;
   uels_pkg::mul_rsp_type mul_rsp;

   uels_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (new_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   uels_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // ---------------------------------------------------------------
   // Operand differences (33-bit, exact)
   // ---------------------------------------------------------------
   logic signed [uels_pkg::DIFF_W-1:0] add_b12, add_k32, add_b23, add_k21;
   logic signed [uels_pkg::DIFF_W-1:0] q_k21, q_b12;
   logic signed [uels_pkg::PROD_W-1:0] q_b12_wide;
   logic signed [uels_pkg::DATA_W-1:0] top_slope, new_slope;
   logic [CW:0]                        mid_sum;
   logic [CW+uels_pkg::KEPT_W-1:0]     kept_wide;

   // pop test: (b1-b2)*(k3-k2) > (b2-b3)*(k2-k1), line 1 below line 2, 3 is new
   assign add_b12 = {rd_data.intercept[uels_pkg::DATA_W-1], rd_data.intercept}
                  - {cur2_ff.intercept[uels_pkg::DATA_W-1], cur2_ff.intercept};
   assign add_k32 = {new_ff.slope[uels_pkg::DATA_W-1], new_ff.slope}
                  - {cur2_ff.slope[uels_pkg::DATA_W-1], cur2_ff.slope};
   assign add_b23 = {cur2_ff.intercept[uels_pkg::DATA_W-1], cur2_ff.intercept}
                  - {new_ff.intercept[uels_pkg::DATA_W-1], new_ff.intercept};
   assign add_k21 = {cur2_ff.slope[uels_pkg::DATA_W-1], cur2_ff.slope}
                  - {cur1_ff.slope[uels_pkg::DATA_W-1], cur1_ff.slope};

   // search step: breakpoint at or left of x when b1-b2 <= x*(k2-k1)
   assign q_k21 = {rd_data.slope[uels_pkg::DATA_W-1], rd_data.slope}
                - {cur1_ff.slope[uels_pkg::DATA_W-1], cur1_ff.slope};
   assign q_b12 = {cur1_ff.intercept[uels_pkg::DATA_W-1], cur1_ff.intercept}
                - {cur2_ff.intercept[uels_pkg::DATA_W-1], cur2_ff.intercept};
   assign q_b12_wide = q_b12;

   assign top_slope = top_ff.slope;
   assign new_slope = req_slope;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi1_ff} - {1'b0, ONE_C};
   assign kept_wide = {{uels_pkg::KEPT_W{1'b0}}, count_ff};

   assign req_ready = (state_ff == uels_pkg::S_IDLE);

   // ---------------------------------------------------------------
   // Sequencer: next state, memory and multiplier control
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      top_in   = top_ff;
      new_in   = new_ff;
      x_in     = x_ff;
      n_in     = n_ff;
      cur1_in  = cur1_ff;
      cur2_in  = cur2_ff;
      lo_in    = lo_ff;
      hi1_in   = hi1_ff;
      mid_in   = mid_ff;
      prod1_in = prod1_ff;
      val_in   = val_ff;
      st_in    = st_ff;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_kept_in   = rsp_kept_ff;

      wr_en       = 1'b0;
      wr_addr     = n_ff[AW-1:0];
      rd_en       = 1'b0;
      rd_addr     = lo_ff[AW-1:0];
      mul_req     = '0;

      case (state_ff)
         uels_pkg::S_IDLE: begin
            if (req_valid) begin
               val_in = '0;
               case (req_func)
                  uels_pkg::FUNC_ADD: begin
                     new_in = {req_slope, req_intercept};
                     if (count_ff != '0 && new_slope <= top_slope) begin
                        st_in    = uels_pkg::ST_SLOPE_BAD;
                        state_in = uels_pkg::S_EMIT;
                     end else begin
                        n_in     = count_ff;
                        cur2_in  = top_ff;
                        state_in = uels_pkg::S_ADD_CHK;
                     end
                  end
                  uels_pkg::FUNC_QUERY: begin
                     x_in = req_query_x;
                     if (count_ff == '0) begin
                        st_in    = uels_pkg::ST_EMPTY;
                        state_in = uels_pkg::S_EMIT;
                     end else begin
                        lo_in    = '0;
                        hi1_in   = count_ff - ONE_C;
                        state_in = uels_pkg::S_Q_CHK;
                     end
                  end
                  default: begin
                     // clear; the unused fourth code decodes the same way
                     count_in = '0;
                     st_in    = uels_pkg::ST_CLEARED;
                     state_in = uels_pkg::S_EMIT;
                  end
               endcase
            end
         end

         // pop loop: fetch the line below the current top candidate
         uels_pkg::S_ADD_CHK: begin
            if (n_ff > ONE_C) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(n_ff - TWO_C);
               state_in = uels_pkg::S_ADD_RD;
            end else begin
               state_in = uels_pkg::S_ADD_END;
            end
         end

         uels_pkg::S_ADD_RD: begin
            cur1_in       = rd_data;
            mul_req.start = 1'b1;
            mul_req.a     = {add_b12[uels_pkg::DIFF_W-1], add_b12};
            mul_req.b     = add_k32;
            state_in      = uels_pkg::S_ADD_M1;
         end

         uels_pkg::S_ADD_M1: begin
            if (mul_rsp.done) begin
               prod1_in      = mul_rsp.product;
               mul_req.start = 1'b1;
               mul_req.a     = {add_b23[uels_pkg::DIFF_W-1], add_b23};
               mul_req.b     = add_k21;
               state_in      = uels_pkg::S_ADD_M2;
            end
         end

         uels_pkg::S_ADD_M2: begin
            if (mul_rsp.done) begin
               if (prod1_ff > mul_rsp.product) begin
                  // drop the top candidate and test the next pair down
                  n_in     = n_ff - ONE_C;
                  cur2_in  = cur1_ff;
                  state_in = uels_pkg::S_ADD_CHK;
               end else begin
                  state_in = uels_pkg::S_ADD_END;
               end
            end
         end

         // commit the pops and the push only when the stack has room
         uels_pkg::S_ADD_END: begin
            if (n_ff >= CAP_C) begin
               st_in = uels_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = n_ff[AW-1:0];
               top_in   = new_ff;
               count_in = n_ff + ONE_C;
               st_in    = uels_pkg::ST_ADDED;
            end
            state_in = uels_pkg::S_EMIT;
         end

         // binary search over breakpoints; lo ends on the best line
         uels_pkg::S_Q_CHK: begin
            rd_en = 1'b1;
            if (lo_ff < hi1_ff) begin
               mid_in   = mid_sum[CW:1];
               rd_addr  = mid_sum[AW:1];
               state_in = uels_pkg::S_Q_RD0;
            end else begin
               rd_addr  = lo_ff[AW-1:0];
               state_in = uels_pkg::S_Q_FRD;
            end
         end

         uels_pkg::S_Q_RD0: begin
            cur1_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(mid_ff + ONE_C);
            state_in = uels_pkg::S_Q_RD1;
         end

         uels_pkg::S_Q_RD1: begin
            cur2_in       = rd_data;
            mul_req.start = 1'b1;
            mul_req.a     = {{2{x_ff[uels_pkg::DATA_W-1]}}, x_ff};
            mul_req.b     = q_k21;
            state_in      = uels_pkg::S_Q_M;
         end

         uels_pkg::S_Q_M: begin
            if (mul_rsp.done) begin
               if (q_b12_wide <= mul_rsp.product) begin
                  lo_in = mid_ff + ONE_C;
               end else begin
                  hi1_in = mid_ff;
               end
               state_in = uels_pkg::S_Q_CHK;
            end
         end

         uels_pkg::S_Q_FRD: begin
            cur1_in       = rd_data;
            mul_req.start = 1'b1;
            mul_req.a     = {{2{rd_data.slope[uels_pkg::DATA_W-1]}}, rd_data.slope};
            mul_req.b     = {x_ff[uels_pkg::DATA_W-1], x_ff};
            state_in      = uels_pkg::S_Q_FM;
         end

         uels_pkg::S_Q_FM: begin
            if (mul_rsp.done) begin
               val_in = mul_rsp.product[uels_pkg::VALUE_W-1:0]
                      + {{(uels_pkg::VALUE_W - uels_pkg::DATA_W)
                          {cur1_ff.intercept[uels_pkg::DATA_W-1]}}, cur1_ff.intercept};
               st_in    = uels_pkg::ST_ANSWERED;
               state_in = uels_pkg::S_EMIT;
            end
         end

         // hand the result to the output register once it is free
         uels_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_status_in = st_ff;
               rsp_kept_in   = kept_wide[uels_pkg::KEPT_W-1:0];
               state_in      = uels_pkg::S_IDLE;
            end
         end

         default: state_in = uels_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uels_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      new_ff        <= new_in;
      x_ff          <= x_in;
      n_ff          <= n_in;
      cur1_ff       <= cur1_in;
      cur2_ff       <= cur2_in;
      lo_ff         <= lo_in;
      hi1_ff        <= hi1_in;
      mid_ff        <= mid_in;
      prod1_ff      <= prod1_in;
      val_ff        <= val_in;
      st_ff         <= st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_kept_ff   <= rsp_kept_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_lines_kept = rsp_kept_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("line count above capacity");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_rsp.busy)
      else $error("multiplier started while busy");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(n_ff) + ONE_C)
      else $error("push did not set the count to height plus one");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == uels_pkg::S_Q_CHK) |-> (lo_ff <= hi1_ff && hi1_ff < count_ff))
      else $error("search window outside the stack");

   a_read_in_stack: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> {{(CW - AW){1'b0}}, rd_addr} < count_ff)
      else $error("read above the top of the stack");
`endif

endmodule
